// ===== rtl/core/b2r_pkg.sv =====
`default_nettype none

package b2r_pkg;

    localparam int HDR_BYTES   = 54;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 104;

    localparam logic [7:0] MAGIC_B      = 8'h42;
    localparam logic [7:0] MAGIC_M      = 8'h4D;
    localparam logic [7:0] DEPTH_24     = 8'd24;
    localparam logic [7:0] DEPTH_32     = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // header byte positions
    localparam logic [5:0] POS_MAGIC0  = 6'd0;
    localparam logic [5:0] POS_MAGIC1  = 6'd1;
    localparam logic [5:0] POS_OFF_LO  = 6'd10;
    localparam logic [5:0] POS_OFF_HI  = 6'd11;
    localparam logic [5:0] POS_WID_LO  = 6'd18;
    localparam logic [5:0] POS_WID_HI  = 6'd19;
    localparam logic [5:0] POS_HGT_LO  = 6'd22;
    localparam logic [5:0] POS_HGT_HI  = 6'd23;
    localparam logic [5:0] POS_DEPTH   = 6'd28;
    // size check precomputed on the bytes after the depth
    localparam logic [5:0] POS_LINE    = 6'd29;
    localparam logic [5:0] POS_PROD    = 6'd30;
    localparam logic [5:0] POS_NEED    = 6'd31;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_MAGIC  = 3'd1,
        ST_BAD_DEPTH  = 3'd2,
        ST_TOO_SHORT  = 3'd3,
        ST_SHORT_HDR  = 3'd4,
        ST_OFF_IN_HDR = 3'd5
    } t_status;

    typedef struct packed {
        logic        has_pix;
        logic [15:0] column;
        logic [14:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        has_stat;
        t_status     status;
        logic [15:0] image_width;
        logic [14:0] image_height;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/core/b2r_decode.sv =====
`default_nettype none

module b2r_decode (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_eof,
    output logic                o_push,
    output b2r_pkg::t_entry     o_entry
);
    import b2r_pkg::*;

    logic [39:0] r_pos, n_pos;
    logic [15:0] r_offset, n_offset;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic        r_four, n_four;
    logic        r_magic_bad, n_magic_bad;
    logic        r_depth_bad, n_depth_bad;
    logic [15:0] r_col, n_col;
    logic [14:0] r_row, n_row;
    logic [1:0]  r_chan, n_chan;
    logic [1:0]  r_pad, n_pad;
    logic [23:0] r_held, n_held;

    logic [17:0] r_line;
    logic [32:0] r_prod;
    logic [33:0] r_need;

    logic        hdr;
    logic [14:0] h;
    logic [40:0] size;
    logic        active;
    logic [1:0]  chan_last;
    logic [17:0] line_bytes;
    t_entry      ent;

    assign hdr       = r_pos < 40'(HDR_BYTES);
    assign h         = r_height[15] ? 15'd0 : r_height[14:0];
    assign size      = {1'b0, r_pos} + 41'd1;
    assign chan_last = r_four ? 2'd3 : 2'd2;
    assign active    = !r_magic_bad && !r_depth_bad
                    && (r_offset >= 16'(HDR_BYTES))
                    && ({24'd0, r_offset} <= r_pos)
                    && (r_width != 16'd0) && (h != 15'd0) && (r_row < h);
    assign line_bytes = r_four ? {r_width, 2'b00}
                      : (({2'b00, r_width} + {1'b0, r_width, 1'b0} + 18'd3) & ~18'd3);

    always_comb begin
        n_pos       = r_pos;
        n_offset    = r_offset;
        n_width     = r_width;
        n_height    = r_height;
        n_four      = r_four;
        n_magic_bad = r_magic_bad;
        n_depth_bad = r_depth_bad;
        n_col       = r_col;
        n_row       = r_row;
        n_chan      = r_chan;
        n_pad       = r_pad;
        n_held      = r_held;
        ent         = '0;

        if (i_fire) begin
            if (hdr) begin
                case (r_pos[5:0])
                    POS_MAGIC0: if (i_byte != MAGIC_B) n_magic_bad = 1'b1;
                    POS_MAGIC1: if (i_byte != MAGIC_M) n_magic_bad = 1'b1;
                    POS_OFF_LO: n_offset[7:0]  = i_byte;
                    POS_OFF_HI: n_offset[15:8] = i_byte;
                    POS_WID_LO: n_width[7:0]   = i_byte;
                    POS_WID_HI: n_width[15:8]  = i_byte;
                    POS_HGT_LO: n_height[7:0]  = i_byte;
                    POS_HGT_HI: n_height[15:8] = i_byte;
                    POS_DEPTH: begin
                        n_depth_bad = (i_byte != DEPTH_24) && (i_byte != DEPTH_32);
                        n_four      = (i_byte == DEPTH_32);
                    end
                    default: ;
                endcase
            end else if (active) begin
                if (r_pad != 2'd0) begin
                    n_pad = r_pad - 2'd1;
                end else if (r_chan == chan_last) begin
                    ent.has_pix = 1'b1;
                    ent.column  = r_col;
                    ent.row     = h - 15'd1 - r_row;
                    ent.blue    = r_held[7:0];
                    ent.green   = r_held[15:8];
                    ent.red     = r_four ? r_held[23:16] : i_byte;
                    ent.alpha   = r_four ? i_byte : ALPHA_OPAQUE;
                    n_chan      = 2'd0;
                    n_held      = '0;
                    if (({1'b0, r_col} + 17'd1) >= {1'b0, r_width}) begin
                        n_col = '0;
                        n_row = r_row + 15'd1;
                        n_pad = r_four ? 2'd0 : r_width[1:0];
                    end else begin
                        n_col = r_col + 16'd1;
                    end
                end else begin
                    case (r_chan)
                        2'd0:    n_held[7:0]   = i_byte;
                        2'd1:    n_held[15:8]  = i_byte;
                        default: n_held[23:16] = i_byte;
                    endcase
                    n_chan = r_chan + 2'd1;
                end
            end

            if (r_pos != '1) n_pos = r_pos + 40'd1;

            if (i_eof) begin
                ent.has_stat = 1'b1;
                if (size < 41'(HDR_BYTES)) begin
                    ent.status = ST_SHORT_HDR;
                end else if (r_magic_bad) begin
                    ent.status = ST_BAD_MAGIC;
                end else begin
                    ent.image_width  = r_width;
                    ent.image_height = h;
                    if (r_depth_bad)                       ent.status = ST_BAD_DEPTH;
                    else if (r_offset < 16'(HDR_BYTES))    ent.status = ST_OFF_IN_HDR;
                    else if (r_height[15])                 ent.status = ST_TOO_SHORT;
                    else if (size < {7'd0, r_need})        ent.status = ST_TOO_SHORT;
                    else                                   ent.status = ST_OK;
                end
                n_pos       = '0;
                n_offset    = '0;
                n_width     = '0;
                n_height    = '0;
                n_four      = 1'b0;
                n_magic_bad = 1'b0;
                n_depth_bad = 1'b0;
                n_col       = '0;
                n_row       = '0;
                n_chan      = '0;
                n_pad       = '0;
                n_held      = '0;
            end
        end
    end

    assign o_push  = ent.has_pix || ent.has_stat;
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_offset    <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_four      <= 1'b0;
            r_magic_bad <= 1'b0;
            r_depth_bad <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_chan      <= '0;
            r_pad       <= '0;
            r_held      <= '0;
        end else begin
            r_pos       <= n_pos;
            r_offset    <= n_offset;
            r_width     <= n_width;
            r_height    <= n_height;
            r_four      <= n_four;
            r_magic_bad <= n_magic_bad;
            r_depth_bad <= n_depth_bad;
            r_col       <= n_col;
            r_row       <= n_row;
            r_chan      <= n_chan;
            r_pad       <= n_pad;
            r_held      <= n_held;
        end
    end

    // padded line bytes, times height, plus offset: one step per header byte
    always_ff @(posedge i_clk) begin
        if (i_fire && r_pos == {34'd0, POS_LINE}) r_line <= line_bytes;
        if (i_fire && r_pos == {34'd0, POS_PROD}) r_prod <= 33'(r_line) * 33'(h);
        if (i_fire && r_pos == {34'd0, POS_NEED}) r_need <= 34'(r_offset) + 34'(r_prod);
    end

endmodule

`default_nettype wire

// ===== rtl/core/b2r_outq.sv =====
`default_nettype none

module b2r_outq (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_push,
    input  wire b2r_pkg::t_entry                    i_entry,
    output logic                                    o_full,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [b2r_pkg::OUT_TDATA_W-1:0]         o_data,
    output logic                                    o_kind,
    output logic                                    o_last
);
    import b2r_pkg::*;

    t_entry      r_q [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic        r_pix_sent;

    t_entry      head;
    logic        show_pix;
    logic        take;
    logic        pop;
    logic        push_ok;

    assign head     = r_q[r_rptr];
    assign o_valid  = r_count != 2'd0;
    assign o_full   = r_count == 2'd2;
    assign show_pix = head.has_pix && !r_pix_sent;
    assign take     = o_valid && i_ready;
    assign pop      = take && !(show_pix && head.has_stat);
    assign push_ok  = i_push && !o_full;

    assign o_kind = !show_pix;
    assign o_last = !show_pix;

    always_comb begin
        o_data = '0;
        if (show_pix) begin
            o_data[15:0]  = head.column;
            o_data[30:16] = head.row;
            o_data[38:31] = head.red;
            o_data[46:39] = head.green;
            o_data[54:47] = head.blue;
            o_data[62:55] = head.alpha;
        end else begin
            o_data[65:63] = head.status;
            o_data[81:66] = head.image_width;
            o_data[96:82] = head.image_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr     <= 1'b0;
            r_rptr     <= 1'b0;
            r_count    <= '0;
            r_pix_sent <= 1'b0;
        end else begin
            if (push_ok) r_wptr <= !r_wptr;
            if (pop)     r_rptr <= !r_rptr;
            r_count <= r_count + {1'b0, push_ok} - {1'b0, pop};
            if (pop)       r_pix_sent <= 1'b0;
            else if (take) r_pix_sent <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_q[r_wptr] <= i_entry;
    end

endmodule

`default_nettype wire

// ===== rtl/core/bmp_to_rgba_stream_decoder.sv =====
`default_nettype none

// BMP file bytes in, RGBA pixels out. One file byte is taken per clock while the
// output keeps up; a byte flows through an input register and the header/pixel
// decode into a two-entry result queue; a result word is offered once its byte
// has left the input register and entered the queue, and the input stalls while
// the queue is full. Each completed pixel gives one word (tuser 0); the byte
// marked tlast also gives a status word (tuser 1, tlast 1) carrying the code and
// image size, so a final byte that completes a pixel gives two output words. Only
// 24- and 32-bit uncompressed bottom-up data is decoded; rows come out flipped so
// the top row is 0. The 54-byte header is required; the file-size check product
// is built over header bytes 29 to 31.
module bmp_to_rgba_stream_decoder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [b2r_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // file_byte
    input  wire logic                                s_axis_tlast,  // end_of_file
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // column, row, red, green, blue, alpha, status, image_width, image_height
    output logic [b2r_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                     m_axis_tuser,  // kind
    output logic                                     m_axis_tlast   // last
);
    import b2r_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eof;
    logic        fire;
    logic        full;
    logic        push;
    t_entry      entry;

    assign fire          = r_in_valid && !full;
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_eof  <= s_axis_tlast;
        end
    end

    b2r_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_eof   (r_in_eof),
        .o_push  (push),
        .o_entry (entry)
    );

    b2r_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_kind  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/core/b2r_checker.sv =====
`default_nettype none

module b2r_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [b2r_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  wire logic                                m_axis_tuser,
    input  wire logic                                m_axis_tlast
);
    import b2r_pkg::*;

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("tlast and status kind disagree");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[65:63] <= 3'd5 && m_axis_tdata[62:0] == '0))
        else $error("status word malformed");

    a_pixel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[103:63] == '0))
        else $error("pixel word carries status fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser)))
        else $error("stalled output word changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

bind bmp_to_rgba_stream_decoder b2r_checker u_b2r_checker (.*);

`default_nettype wire

// ===== test/tb_bmp_to_rgba_stream_decoder.sv =====
`timescale 1ns / 100ps

module tb_bmp_to_rgba_stream_decoder;

    import b2r_pkg::*;

    localparam bit KIND_PIXEL  = 1'b0;
    localparam bit KIND_STATUS = 1'b1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1600;

    typedef struct packed {
        bit          kind;
        bit [15:0]   column;
        bit [14:0]   row;
        bit [7:0]    red;
        bit [7:0]    green;
        bit [7:0]    blue;
        bit [7:0]    alpha;
        t_status     status;
        bit [15:0]   image_width;
        bit [14:0]   image_height;
        bit          last;
    } rgba_word_t;

    class bmp_scoreboard;
        bit [39:0]  file_pos;
        bit [15:0]  pix_offset;
        bit [15:0]  hdr_width;
        bit [15:0]  hdr_height;
        bit         rgba_depth;
        bit         magic_err;
        bit         depth_err;
        bit [15:0]  col_cnt;
        bit [14:0]  row_cnt;
        bit [1:0]   chan_cnt;
        bit [1:0]   pad_cnt;
        bit [23:0]  held;
        rgba_word_t pending_words[$];
        int unsigned errors;

        function new();
            errors = 0;
            clear_file();
        endfunction

        function void clear_file();
            file_pos   = '0;
            pix_offset = '0;
            hdr_width  = '0;
            hdr_height = '0;
            rgba_depth = 1'b0;
            magic_err  = 1'b0;
            depth_err  = 1'b0;
            col_cnt    = '0;
            row_cnt    = '0;
            chan_cnt   = '0;
            pad_cnt    = '0;
            held       = '0;
        endfunction

        function void expect_word(rgba_word_t w);
            pending_words = {pending_words, w};
        endfunction

        function bit [14:0] rows_in_image();
            return hdr_height[15] ? 15'd0 : hdr_height[14:0];
        endfunction

        // accepted file byte: advance the decoder copy and queue what it yields
        function void note_byte(bit [7:0] value, bit eof);
            bit [39:0]          pos;
            bit [14:0]          h;
            bit [1:0]           last_chan;
            longint unsigned    size;
            longint unsigned    line;
            longint unsigned    need;
            rgba_word_t         w;
            pos = file_pos;
            if (pos < HDR_BYTES) begin
                case (pos[5:0])
                    POS_MAGIC0: if (value != MAGIC_B) magic_err = 1'b1;
                    POS_MAGIC1: if (value != MAGIC_M) magic_err = 1'b1;
                    POS_OFF_LO: pix_offset[7:0]  = value;
                    POS_OFF_HI: pix_offset[15:8] = value;
                    POS_WID_LO: hdr_width[7:0]   = value;
                    POS_WID_HI: hdr_width[15:8]  = value;
                    POS_HGT_LO: hdr_height[7:0]  = value;
                    POS_HGT_HI: hdr_height[15:8] = value;
                    POS_DEPTH: begin
                        depth_err  = (value != DEPTH_24) && (value != DEPTH_32);
                        rgba_depth = (value == DEPTH_32);
                    end
                    default: ;
                endcase
            end else begin
                h = rows_in_image();
                if (!magic_err && !depth_err && pix_offset >= HDR_BYTES &&
                    pos >= pix_offset && hdr_width != 0 && h != 0 && row_cnt < h) begin
                    last_chan = rgba_depth ? 2'd3 : 2'd2;
                    if (pad_cnt != 0) begin
                        pad_cnt--;
                    end else if (chan_cnt == last_chan) begin
                        w = '0;
                        w.kind   = KIND_PIXEL;
                        w.column = col_cnt;
                        w.row    = h - 15'd1 - row_cnt;
                        w.blue   = held[7:0];
                        w.green  = held[15:8];
                        w.red    = rgba_depth ? held[23:16] : value;
                        w.alpha  = rgba_depth ? value : ALPHA_OPAQUE;
                        expect_word(w);
                        chan_cnt = '0;
                        held     = '0;
                        if (int'(col_cnt) + 1 >= int'(hdr_width)) begin
                            col_cnt = '0;
                            row_cnt++;
                            pad_cnt = rgba_depth ? 2'd0
                                : 2'((4 - (int'(hdr_width) * 3) % 4) % 4);
                        end else begin
                            col_cnt++;
                        end
                    end else begin
                        held = held | (24'(value) << (8 * chan_cnt));
                        chan_cnt++;
                    end
                end
            end
            if (file_pos != '1) file_pos++;

            if (eof) begin
                size = longint'(pos) + 1;
                w = '0;
                w.kind   = KIND_STATUS;
                w.last   = 1'b1;
                w.status = ST_OK;
                if (size < HDR_BYTES) begin
                    w.status = ST_SHORT_HDR;
                end else if (magic_err) begin
                    w.status = ST_BAD_MAGIC;
                end else begin
                    w.image_width  = hdr_width;
                    w.image_height = rows_in_image();
                    if (depth_err) begin
                        w.status = ST_BAD_DEPTH;
                    end else if (pix_offset < HDR_BYTES) begin
                        w.status = ST_OFF_IN_HDR;
                    end else if (hdr_height[15]) begin
                        w.status = ST_TOO_SHORT;
                    end else begin
                        line = longint'(hdr_width) * (rgba_depth ? 4 : 3);
                        line = (line + 3) & ~longint'(3);
                        need = longint'(pix_offset) + line * longint'(rows_in_image());
                        w.status = (size < need) ? ST_TOO_SHORT : ST_OK;
                    end
                end
                expect_word(w);
                clear_file();
            end
        endfunction

        function void compare_field(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_word(bit kind, bit [OUT_TDATA_W-1:0] data, bit last);
            rgba_word_t got;
            rgba_word_t want;
            got = '0;
            got.kind         = kind;
            got.column       = data[15:0];
            got.row          = data[30:16];
            got.red          = data[38:31];
            got.green        = data[46:39];
            got.blue         = data[54:47];
            got.alpha        = data[62:55];
            got.status       = t_status'(data[65:63]);
            got.image_width  = data[81:66];
            got.image_height = data[96:82];
            got.last         = last;
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none actual 0x%0h", $time, got);
                return;
            end
            want = pending_words.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("column", want.column, got.column);
            compare_field("row", want.row, got.row);
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("alpha", want.alpha, got.alpha);
            compare_field("status", want.status, got.status);
            compare_field("image_width", want.image_width, got.image_width);
            compare_field("image_height", want.image_height, got.image_height);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // file_byte
    logic                   s_axis_tlast = 1'b0; // end_of_file
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // column, row, red, green, blue, alpha, status, image_width, image_height
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;        // kind
    logic                   m_axis_tlast;        // last

    bmp_to_rgba_stream_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    bmp_scoreboard sb = new();

    bit [7:0]    file_bytes[$];
    int          burst_left = 0;
    int          bytes_sent = 0;
    int unsigned cycle_count = 0;
    int          rx_mode = 0;
    bit [15:0]   rx_pattern = 16'hFFFF;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver stall pattern, plus run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bmp_to_rgba_stream_decoder verification failed");
            $finish;
        end
        if (cycle_count[6:0] == 7'd0) begin
            rx_mode    = $urandom_range(0, 3);
            rx_pattern = 16'($urandom) | 16'h0001;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= rx_pattern[cycle_count[3:0]];
            2: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_word(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    function automatic int full_length(bit [15:0] offset, bit [15:0] width,
                                       bit [15:0] height, bit [7:0] depth);
        int line;
        line = int'(width) * ((depth == DEPTH_32) ? 4 : 3);
        line = (line + 3) & ~3;
        return int'(offset) + (height[15] ? 0 : line * int'(height));
    endfunction

    function automatic void build_file(bit [7:0] magic0, bit [7:0] magic1, bit [15:0] offset,
                                       bit [15:0] width, bit [15:0] height, bit [7:0] depth,
                                       int len);
        bit [7:0] b;
        file_bytes.delete();
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            case (i)
                POS_MAGIC0: b = magic0;
                POS_MAGIC1: b = magic1;
                POS_OFF_LO: b = offset[7:0];
                POS_OFF_HI: b = offset[15:8];
                POS_WID_LO: b = width[7:0];
                POS_WID_HI: b = width[15:8];
                POS_HGT_LO: b = height[7:0];
                POS_HGT_HI: b = height[15:8];
                POS_DEPTH:  b = depth;
                default: ;
            endcase
            file_bytes = {file_bytes, b};
        end
    endfunction

    task automatic send_byte(input bit [7:0] value, input bit eof);
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(64, 256);
            end else begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= eof;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(value, eof);
        burst_left--;
    endtask

    task automatic play_file();
        foreach (file_bytes[i]) begin
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
            bytes_sent++;
        end
    endtask

    task automatic send_image(bit [7:0] magic0, bit [7:0] magic1, bit [15:0] offset,
                              bit [15:0] width, bit [15:0] height, bit [7:0] depth,
                              int len);
        build_file(magic0, magic1, offset, width, height, depth, len);
        play_file();
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_file();
        bit [7:0]  m0;
        bit [7:0]  m1;
        bit [15:0] offset;
        bit [15:0] width;
        bit [15:0] height;
        bit [7:0]  depth;
        int        len;
        m0     = MAGIC_B;
        m1     = MAGIC_M;
        width  = 16'($urandom_range(1, 9));
        height = 16'($urandom_range(1, 5));
        depth  = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
        offset = 16'(HDR_BYTES);
        if ($urandom_range(0, 3) == 0) offset = offset + 16'($urandom_range(1, 20));
        len = full_length(offset, width, height, depth);
        if ($urandom_range(0, 3) == 0) len = len + $urandom_range(1, 6);
        if ($urandom_range(0, 99) >= 75) begin
            case ($urandom_range(0, 7))
                0: begin
                    if ($urandom_range(0, 1)) m0 = MAGIC_B ^ 8'($urandom_range(1, 255));
                    else m1 = MAGIC_M ^ 8'($urandom_range(1, 255));
                end
                1: depth = 8'($urandom);
                2: offset = 16'($urandom_range(0, HDR_BYTES - 1));
                3: height = 16'h8000 | 16'($urandom);
                4: begin
                    if ($urandom_range(0, 1)) width = '0;
                    else height = '0;
                end
                5: len = $urandom_range(HDR_BYTES, len - 1);
                6: len = $urandom_range(1, HDR_BYTES - 1);
                default: begin
                    width  = 16'($urandom);
                    height = 16'($urandom_range(0, 32767));
                    len    = int'(offset) + $urandom_range(0, 60);
                end
            endcase
        end
        send_image(m0, m1, offset, width, height, depth, len);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // well-formed images, every padding amount, pixel ending on end of file
        send_image(MAGIC_B, MAGIC_M, 54, 1, 2, DEPTH_24, full_length(54, 1, 2, DEPTH_24));
        send_image(MAGIC_B, MAGIC_M, 60, 2, 2, DEPTH_32, full_length(60, 2, 2, DEPTH_32) + 3);
        send_image(MAGIC_B, MAGIC_M, 54, 4, 1, DEPTH_24, full_length(54, 4, 1, DEPTH_24));
        send_image(MAGIC_B, MAGIC_M, 57, 2, 3, DEPTH_24, full_length(57, 2, 3, DEPTH_24));
        send_image(MAGIC_B, MAGIC_M, 54, 3, 2, DEPTH_24, full_length(54, 3, 2, DEPTH_24));
        send_image(MAGIC_B, MAGIC_M, 16'h0100, 2, 2, DEPTH_32,
                   full_length(16'h0100, 2, 2, DEPTH_32));
        // short header, also with a broken magic
        send_image(MAGIC_B, MAGIC_M, 54, 1, 1, DEPTH_24, 1);
        send_image(MAGIC_B, 8'h58, 54, 1, 1, DEPTH_24, HDR_BYTES - 1);
        // header errors and their priority
        send_image(8'h58, MAGIC_M, 54, 2, 2, 8'd16, full_length(54, 2, 2, DEPTH_24));
        send_image(MAGIC_B, MAGIC_M, 54, 2, 2, 8'd16, full_length(54, 2, 2, DEPTH_24));
        send_image(MAGIC_B, MAGIC_M, 54, 2, 1, 8'd255, full_length(54, 2, 1, DEPTH_32));
        send_image(MAGIC_B, MAGIC_M, 53, 2, 2, DEPTH_24, full_length(54, 2, 2, DEPTH_24));
        send_image(MAGIC_B, MAGIC_M, 0, 1, 1, DEPTH_32, 70);
        // negative height, zero size
        send_image(MAGIC_B, MAGIC_M, 54, 2, 16'hFFFF, DEPTH_24, 70);
        send_image(MAGIC_B, MAGIC_M, 54, 1, 16'h8000, DEPTH_32, 64);
        send_image(MAGIC_B, MAGIC_M, 54, 0, 3, DEPTH_24, 62);
        send_image(MAGIC_B, MAGIC_M, 54, 3, 0, DEPTH_32, 54);
        // short pixel data, ending inside a pixel
        send_image(MAGIC_B, MAGIC_M, 54, 3, 3, DEPTH_24, full_length(54, 3, 3, DEPTH_24) - 5);
        // largest sizes in the header with only a few pixels present
        send_image(MAGIC_B, MAGIC_M, 54, 16'hFFFF, 16'h7FFF, DEPTH_32, HDR_BYTES + 40);
        send_image(MAGIC_B, MAGIC_M, 54, 16'hFFFF, 1, DEPTH_24, HDR_BYTES + 30);

        drain_results();

        while (bytes_sent < ITEM_TARGET) begin
            random_file();
            if ($urandom_range(0, 19) == 0) drain_results();
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("bmp_to_rgba_stream_decoder verification clean");
        end else begin
            $display("bmp_to_rgba_stream_decoder verification failed");
        end
        $finish;
    end

endmodule
